>>> src/afc_pkg.sv
// package: types, datapath commands and predictor coefficient table for the adpcm decoder
`default_nettype none
package afc_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned FRAC_BITS   = 11;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned ACC_W       = 32;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_OUT
  } afc_state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL1,
    OP_MUL2,
    OP_SUM
  } afc_op_t;

  typedef struct packed {
    logic    load_hdr;
    logic    load_byte;
    logic    last;
    logic    nib_low;
    afc_op_t op;
    logic    load_out;
  } afc_cmd_t;

  function automatic logic signed [SAMPLE_W-1:0] coef_c0(input logic [3:0] sel);
    logic signed [SAMPLE_W-1:0] c;
    case (sel)
      4'd0:    c = 16'sh0000;
      4'd1:    c = 16'sh0800;
      4'd2:    c = 16'sh0000;
      4'd3:    c = 16'sh0400;
      4'd4:    c = 16'sh1000;
      4'd5:    c = 16'sh0e00;
      4'd6:    c = 16'sh0c00;
      4'd7:    c = 16'sh1200;
      4'd8:    c = 16'sh1068;
      4'd9:    c = 16'sh12c0;
      4'd10:   c = 16'sh1400;
      4'd11:   c = 16'sh0800;
      4'd12:   c = 16'sh0400;
      4'd13:   c = -16'sh0400;
      4'd14:   c = -16'sh0400;
      4'd15:   c = -16'sh0800;
      default: c = 16'sh0000;
    endcase
    return c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] coef_c1(input logic [3:0] sel);
    logic signed [SAMPLE_W-1:0] c;
    case (sel)
      4'd0:    c = 16'sh0000;
      4'd1:    c = 16'sh0000;
      4'd2:    c = 16'sh0800;
      4'd3:    c = 16'sh0400;
      4'd4:    c = -16'sh0800;
      4'd5:    c = -16'sh0600;
      4'd6:    c = -16'sh0400;
      4'd7:    c = -16'sh0a00;
      4'd8:    c = -16'sh08c8;
      4'd9:    c = -16'sh08fc;
      4'd10:   c = -16'sh0c00;
      4'd11:   c = -16'sh0800;
      4'd12:   c = -16'sh0400;
      4'd13:   c = 16'sh0400;
      4'd14:   c = 16'sh0000;
      4'd15:   c = 16'sh0000;
      default: c = 16'sh0000;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/afc_adpcm_frame_decoder.sv
// top level: 4-bit adpcm frame decoder, controller plus datapath
//
//   channel | ports                                           | dir
//   in      | in_valid, in_ready, in_frame_byte[7:0]          | input beat, one frame byte
//   out     | out_valid, out_ready, out_sample_first[15:0],   | output beat, two samples
//           | out_sample_second[15:0], out_frame_last         |
//
// a header byte is latched in idle; a data byte runs through the controller: accept,
// then mul1, mul2, sum per nibble on the one shared 16x16 multiplier, then output load
// the output register lets the next byte be accepted while a result beat waits
// a data byte stalls in the output load cycle until the output register is free
// rst_n is synchronous; it clears position, header fields and both histories
`default_nettype none
module afc_adpcm_frame_decoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_frame_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [15:0]       out_sample_first,
  output logic signed [15:0]       out_sample_second,
  output logic                     out_frame_last
);

  afc_pkg::afc_cmd_t cmd;

  afc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  afc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_frame_byte     (in_frame_byte),
    .out_sample_first  (out_sample_first),
    .out_sample_second (out_sample_second),
    .out_frame_last    (out_frame_last)
  );

endmodule
`default_nettype wire

>>> src/afc_ctrl.sv
// controller: byte position, nibble sequencing and output beat handshake
`default_nettype none
module afc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output afc_pkg::afc_cmd_t     cmd
);

  afc_pkg::afc_state_t                state_r, state_nxt;
  logic [afc_pkg::POS_W-1:0]          pos_r, pos_nxt;
  logic                               nib_r, nib_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               is_hdr;
  logic                               out_free;

  assign is_hdr   = (pos_r == '0) || (pos_r >= afc_pkg::POS_W'(afc_pkg::FRAME_BYTES));
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= afc_pkg::ST_IDLE;
      pos_r       <= '0;
      nib_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      nib_r       <= nib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    nib_nxt   = nib_r;
    case (state_r)
      afc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (is_hdr) begin
            pos_nxt = afc_pkg::POS_W'(1);
          end else begin
            pos_nxt   = (pos_r == afc_pkg::POS_W'(afc_pkg::FRAME_BYTES - 1)) ?
                        '0 : pos_r + afc_pkg::POS_W'(1);
            nib_nxt   = 1'b0;
            state_nxt = afc_pkg::ST_MUL1;
          end
        end
      end
      afc_pkg::ST_MUL1: state_nxt = afc_pkg::ST_MUL2;
      afc_pkg::ST_MUL2: state_nxt = afc_pkg::ST_SUM;
      afc_pkg::ST_SUM: begin
        if (!nib_r) begin
          nib_nxt   = 1'b1;
          state_nxt = afc_pkg::ST_MUL1;
        end else begin
          state_nxt = afc_pkg::ST_OUT;
        end
      end
      afc_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = afc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = afc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.op        = afc_pkg::OP_NONE;
    cmd.nib_low   = nib_r;
    cmd.last      = (pos_r == afc_pkg::POS_W'(afc_pkg::FRAME_BYTES - 1));
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      afc_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_hdr  = in_valid && is_hdr;
        cmd.load_byte = in_valid && !is_hdr;
      end
      afc_pkg::ST_MUL1: cmd.op = afc_pkg::OP_MUL1;
      afc_pkg::ST_MUL2: cmd.op = afc_pkg::OP_MUL2;
      afc_pkg::ST_SUM:  cmd.op = afc_pkg::OP_SUM;
      afc_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = afc_pkg::OP_NONE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> src/afc_dp.sv
// datapath: header fields, shared predictor multiplier, accumulate, saturate, histories
`default_nettype none
module afc_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire afc_pkg::afc_cmd_t              cmd,
  input  wire logic [7:0]                     in_frame_byte,
  output logic signed [afc_pkg::SAMPLE_W-1:0] out_sample_first,
  output logic signed [afc_pkg::SAMPLE_W-1:0] out_sample_second,
  output logic                                out_frame_last
);

  localparam int unsigned SW = afc_pkg::SAMPLE_W;
  localparam int unsigned AW = afc_pkg::ACC_W;

  logic [3:0]           exp_r, coef_r;
  logic [7:0]           byte_r;
  logic                 last_r;
  logic signed [SW-1:0] h1_r, h2_r;
  logic signed [AW-1:0] acc_r, prod_r;
  logic signed [SW-1:0] s0_r, s1_r;
  logic signed [SW-1:0] first_r, second_r;
  logic                 frame_last_r;

  logic [3:0]           nib;
  logic signed [AW-1:0] nib_ext, delta_sh, delta;
  logic signed [SW-1:0] mul_a, mul_b;
  logic signed [AW-1:0] mul_p;
  logic signed [AW-1:0] sum, sum_sh;
  logic signed [SW-1:0] samp;

  assign nib      = cmd.nib_low ? byte_r[3:0] : byte_r[7:4];
  assign nib_ext  = AW'(signed'(nib));
  assign delta_sh = nib_ext <<< (5'(exp_r) + 5'(afc_pkg::FRAC_BITS));
  // exponent fifteen wraps the 16-bit scale to its negative limit
  assign delta    = (exp_r == 4'hf) ? -delta_sh : delta_sh;

  assign mul_a = (cmd.op == afc_pkg::OP_MUL2) ? h2_r : h1_r;
  assign mul_b = (cmd.op == afc_pkg::OP_MUL2) ? afc_pkg::coef_c1(coef_r)
                                              : afc_pkg::coef_c0(coef_r);
  assign mul_p = AW'(mul_a) * AW'(mul_b);

  assign sum    = acc_r + prod_r;
  assign sum_sh = sum >>> afc_pkg::FRAC_BITS;
  always_comb begin
    if (sum_sh > AW'(afc_pkg::SAMPLE_MAX)) begin
      samp = afc_pkg::SAMPLE_MAX;
    end else if (sum_sh < AW'(afc_pkg::SAMPLE_MIN)) begin
      samp = afc_pkg::SAMPLE_MIN;
    end else begin
      samp = sum_sh[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= '0;
      coef_r <= '0;
      h1_r   <= '0;
      h2_r   <= '0;
    end else begin
      if (cmd.load_hdr) begin
        exp_r  <= in_frame_byte[7:4];
        coef_r <= in_frame_byte[3:0];
      end
      if (cmd.op == afc_pkg::OP_SUM) begin
        h2_r <= h1_r;
        h1_r <= samp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_r <= in_frame_byte;
      last_r <= cmd.last;
    end
    case (cmd.op)
      afc_pkg::OP_MUL1: begin
        prod_r <= mul_p;
        acc_r  <= delta;
      end
      afc_pkg::OP_MUL2: begin
        prod_r <= mul_p;
        acc_r  <= sum;
      end
      afc_pkg::OP_SUM: begin
        if (cmd.nib_low) begin
          s1_r <= samp;
        end else begin
          s0_r <= samp;
        end
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      first_r      <= s0_r;
      second_r     <= s1_r;
      frame_last_r <= last_r;
    end
  end

  assign out_sample_first  = first_r;
  assign out_sample_second = second_r;
  assign out_frame_last    = frame_last_r;

endmodule
`default_nettype wire

>>> bench/tb.sv
// testbench for the adpcm frame decoder: directed and random frames checked against a predictor
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic signed [15:0] first;
    logic signed [15:0] second;
    logic               last;
  } sample_pair_t;

  // predictor coefficient pairs, entry 0 in the low bits
  localparam logic [255:0] PAIR_C0 = {
    -16'sh0800, -16'sh0400, -16'sh0400, 16'sh0400,
    16'sh0800, 16'sh1400, 16'sh12c0, 16'sh1068,
    16'sh1200, 16'sh0c00, 16'sh0e00, 16'sh1000,
    16'sh0400, 16'sh0000, 16'sh0800, 16'sh0000
  };
  localparam logic [255:0] PAIR_C1 = {
    16'sh0000, 16'sh0000, 16'sh0400, -16'sh0400,
    -16'sh0800, -16'sh0c00, -16'sh08fc, -16'sh08c8,
    -16'sh0a00, -16'sh0400, -16'sh0600, -16'sh0800,
    16'sh0400, 16'sh0800, 16'sh0000, 16'sh0000
  };

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_frame_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_sample_first;
  logic signed [15:0] out_sample_second;
  logic               out_frame_last;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;

  logic [3:0]         frame_pos = '0;
  logic [3:0]         hdr_exp = '0;
  logic [3:0]         hdr_sel = '0;
  logic signed [15:0] hist_one = '0;
  logic signed [15:0] hist_two = '0;
  sample_pair_t       pending_pairs[$];

  afc_adpcm_frame_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_frame_byte    (in_frame_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_first (out_sample_first),
    .out_sample_second(out_sample_second),
    .out_frame_last   (out_frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [15:0] decode_nibble(input logic [3:0] nib);
    logic signed [15:0] scale;
    logic signed [3:0]  n;
    logic signed [15:0] c0;
    logic signed [15:0] c1;
    longint             acc;
    longint             q;
    logic signed [15:0] s;
    scale = 16'h0001 << hdr_exp;
    n = nib;
    c0 = PAIR_C0[hdr_sel*16 +: 16];
    c1 = PAIR_C1[hdr_sel*16 +: 16];
    acc = longint'(scale) * longint'(n) * 2048 + longint'(hist_one) * longint'(c0)
        + longint'(hist_two) * longint'(c1);
    q = acc >>> afc_pkg::FRAC_BITS;
    if (q > 32767) s = afc_pkg::SAMPLE_MAX;
    else if (q < -32768) s = afc_pkg::SAMPLE_MIN;
    else s = q[15:0];
    hist_two = hist_one;
    hist_one = s;
    return s;
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    sample_pair_t p;
    if (frame_pos == 0 || frame_pos >= afc_pkg::FRAME_BYTES) begin
      hdr_exp = b[7:4];
      hdr_sel = b[3:0];
      frame_pos = 4'd1;
    end else begin
      p.first = decode_nibble(b[7:4]);
      p.second = decode_nibble(b[3:0]);
      p.last = (frame_pos == afc_pkg::FRAME_BYTES - 1);
      frame_pos = p.last ? 4'd0 : frame_pos + 4'd1;
      pending_pairs.push_back(p);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_frame_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_byte <= b;
    do @(posedge clk); while (!in_ready);
    absorb_byte(b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_data_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h77;
      3: return 8'h88;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic [7:0] header);
    send_byte(header);
    repeat (afc_pkg::FRAME_BYTES - 1) send_byte(random_data_byte());
  endtask

  // exponent extremes, nibble extremes, history carried into the next frame
  task automatic test_extremes();
    logic [7:0] frame_a [9];
    logic [7:0] frame_b [9];
    frame_a = '{8'hf7, 8'h00, 8'hff, 8'h80, 8'h7f, 8'h88, 8'h77, 8'h08, 8'hf0};
    frame_b = '{8'h0a, 8'h77, 8'h77, 8'h88, 8'h88, 8'h00, 8'h00, 8'h7f, 8'hf8};
    foreach (frame_a[i]) send_byte(frame_a[i]);
    foreach (frame_b[i]) send_byte(frame_b[i]);
    send_frame(8'hf9);
  endtask

  task automatic test_all_coef_pairs();
    for (int sel = 0; sel < 16; sel++) send_frame({4'($urandom_range(15)), 4'(sel)});
  endtask

  task automatic test_random_stream(input int frames);
    repeat (frames) send_frame(8'($urandom));
  endtask

  // stop mid-frame until every pending beat has come out, then finish the frame
  task automatic test_drain_pause();
    send_byte({4'($urandom_range(15)), 4'($urandom_range(15))});
    repeat (4) send_byte(random_data_byte());
    wait_drained();
    repeat (afc_pkg::FRAME_BYTES - 5) send_byte(random_data_byte());
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    sample_pair_t exp_pair;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected beat first=%h second=%h last=%b", $time,
                 out_sample_first, out_sample_second, out_frame_last);
        mismatch_count++;
      end else begin
        exp_pair = pending_pairs.pop_front();
        if (out_sample_first !== exp_pair.first) begin
          $display("%0t: sample_first expected %h actual %h", $time,
                   exp_pair.first, out_sample_first);
          mismatch_count++;
        end
        if (out_sample_second !== exp_pair.second) begin
          $display("%0t: sample_second expected %h actual %h", $time,
                   exp_pair.second, out_sample_second);
          mismatch_count++;
        end
        if (out_frame_last !== exp_pair.last) begin
          $display("%0t: frame_last expected %b actual %b", $time,
                   exp_pair.last, out_frame_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 76;
    test_extremes();
    test_all_coef_pairs();
    test_random_stream(50);
    wait_drained();

    send_idle_pct = 76;
    recv_idle_pct = 29;
    test_random_stream(30);
    test_drain_pause();
    test_random_stream(30);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(59);
    wait_drained();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
src/afc_pkg.sv
src/afc_ctrl.sv
src/afc_dp.sv
src/afc_adpcm_frame_decoder.sv
bench/tb.sv
